// ===== rtl/core/motion_reward_sequencer_macros.svh =====
// Assertion macros for the motion reward sequencer.
// Included by modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef MOTION_REWARD_SEQUENCER_MACROS_SVH
`define MOTION_REWARD_SEQUENCER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MRS_ASSERT_NOW(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("motion_reward_sequencer: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define MRS_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("motion_reward_sequencer: next-cycle check failed");

`endif

// ===== rtl/core/mrs_pkg.sv =====
// Shared types, constants and helpers for the motion reward sequencer.
// No dependencies.
package mrs_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int VEL_WIDTH     = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_VEL_THRESHOLD   = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RUN_TICKS_NEED  = CFG_IDX_WIDTH'(1);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STILL_TICKS_NEED = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MOTION_MODE_TICKS = CFG_IDX_WIDTH'(3);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_STILL_MODE_TICKS = CFG_IDX_WIDTH'(4);

    // Mode codes as reported on the output
    localparam logic [1:0] CODE_WAIT_MOTION   = 2'd0;
    localparam logic [1:0] CODE_REWARD_MOTION = 2'd1;
    localparam logic [1:0] CODE_WAIT_STILL    = 2'd2;
    localparam logic [1:0] CODE_REWARD_STILL  = 2'd3;

    typedef enum logic [3:0] {
        MODE_WAIT_MOTION   = 4'b0001,
        MODE_REWARD_MOTION = 4'b0010,
        MODE_WAIT_STILL    = 4'b0100,
        MODE_REWARD_STILL  = 4'b1000
    } t_mode;

    typedef struct packed {
        logic signed [CFG_WIDTH-1:0] velocity_threshold;
        logic [CFG_WIDTH-1:0]        running_ticks_needed;
        logic [CFG_WIDTH-1:0]        still_ticks_needed;
        logic [CFG_WIDTH-1:0]        motion_mode_ticks;
        logic [CFG_WIDTH-1:0]        still_mode_ticks;
    } t_cfg;

    typedef struct packed {
        t_mode                  mode;
        logic [COUNT_WIDTH-1:0] running_count;
        logic [COUNT_WIDTH-1:0] still_count;
        logic [COUNT_WIDTH-1:0] dwell_count;
    } t_state;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] code;
        unique case (m)
            MODE_WAIT_MOTION:   code = CODE_WAIT_MOTION;
            MODE_REWARD_MOTION: code = CODE_REWARD_MOTION;
            MODE_WAIT_STILL:    code = CODE_WAIT_STILL;
            MODE_REWARD_STILL:  code = CODE_REWARD_STILL;
            default:            code = CODE_WAIT_MOTION;
        endcase
        return code;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_WIDTH'(1);
    endfunction

    // count >= threshold, both zero-extended to a common width
    function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                     input logic [CFG_WIDTH-1:0] thr);
        return CMP_WIDTH'(c) >= CMP_WIDTH'(thr);
    endfunction

endpackage

// ===== rtl/core/mrs_cfg_regs.sv =====
// Configuration register file for the motion reward sequencer.
// Depends on mrs_pkg.
module mrs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr_en,
    input  logic [mrs_pkg::CFG_IDX_WIDTH-1:0] i_wr_index,
    input  logic [mrs_pkg::CFG_WIDTH-1:0]     i_wr_data,
    output mrs_pkg::t_cfg                    o_cfg
);

    mrs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                mrs_pkg::CFG_VEL_THRESHOLD:     r_cfg.velocity_threshold   <= i_wr_data;
                mrs_pkg::CFG_RUN_TICKS_NEED:    r_cfg.running_ticks_needed <= i_wr_data;
                mrs_pkg::CFG_STILL_TICKS_NEED:  r_cfg.still_ticks_needed   <= i_wr_data;
                mrs_pkg::CFG_MOTION_MODE_TICKS: r_cfg.motion_mode_ticks    <= i_wr_data;
                mrs_pkg::CFG_STILL_MODE_TICKS:  r_cfg.still_mode_ticks     <= i_wr_data;
                default: ;  // unknown index, dropped
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/mrs_step.sv =====
// One tick of the reward sequencer: classify, count, mode decision.
// Pure combinational; depends on mrs_pkg.
module mrs_step (
    input  logic signed [mrs_pkg::VEL_WIDTH-1:0] i_velocity,
    input  mrs_pkg::t_cfg                        i_cfg,
    input  mrs_pkg::t_state                      i_state,
    output mrs_pkg::t_state                      o_state,
    output logic                                 o_pulse
);

    logic moving;

    always_comb begin
        moving  = i_velocity > i_cfg.velocity_threshold;
        o_state = i_state;
        o_pulse = 1'b0;

        if (moving) begin
            o_state.still_count   = '0;
            o_state.running_count = mrs_pkg::sat_inc(i_state.running_count);
        end else begin
            o_state.running_count = '0;
            o_state.still_count   = mrs_pkg::sat_inc(i_state.still_count);
        end

        unique case (i_state.mode)
            mrs_pkg::MODE_WAIT_MOTION: begin
                if (mrs_pkg::reached(o_state.running_count, i_cfg.running_ticks_needed)) begin
                    o_pulse               = 1'b1;
                    o_state.running_count = '0;
                    o_state.mode          = mrs_pkg::MODE_REWARD_MOTION;
                end
            end
            mrs_pkg::MODE_REWARD_MOTION: begin
                o_state.dwell_count = mrs_pkg::sat_inc(i_state.dwell_count);
                if (mrs_pkg::reached(o_state.dwell_count, i_cfg.motion_mode_ticks)) begin
                    o_state.dwell_count = '0;
                    o_state.mode        = mrs_pkg::MODE_WAIT_STILL;
                end
                if (mrs_pkg::reached(o_state.running_count, i_cfg.running_ticks_needed)) begin
                    o_pulse               = 1'b1;
                    o_state.running_count = '0;
                end
            end
            mrs_pkg::MODE_WAIT_STILL: begin
                if (mrs_pkg::reached(o_state.still_count, i_cfg.still_ticks_needed)) begin
                    o_pulse             = 1'b1;
                    o_state.still_count = '0;
                    o_state.mode        = mrs_pkg::MODE_REWARD_STILL;
                end
            end
            default: begin  // reward for stillness
                o_state.dwell_count = mrs_pkg::sat_inc(i_state.dwell_count);
                if (mrs_pkg::reached(o_state.dwell_count, i_cfg.still_mode_ticks)) begin
                    o_state.dwell_count = '0;
                    o_state.mode        = mrs_pkg::MODE_WAIT_MOTION;
                end
                if (mrs_pkg::reached(o_state.still_count, i_cfg.still_ticks_needed)) begin
                    o_pulse             = 1'b1;
                    o_state.still_count = '0;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/motion_reward_sequencer.sv =====
// Motion reward sequencer top level: input beat register, step logic, result register.
// Depends on mrs_pkg, mrs_cfg_regs, mrs_step and motion_reward_sequencer_macros.svh.
//
// Usage:
//  - Input channel: one beat per frame tick carrying a signed Q3.12 velocity
//    (i_in_valid / o_in_stall / i_velocity).
//  - Output channel: one beat per input beat with reward pulse, mode after the
//    step and a packed status word (o_out_valid / i_out_stall / o_*).
//  - Config channel: i_cfg_valid / o_cfg_ready with a register index and 16-bit
//    data; o_cfg_ready is always high. Write only while no beat is in flight.
//    Unknown indexes are ignored.
//  - Path: an input beat passes the input register, then the result register,
//    to the output. Throughput: one beat per cycle while the output is not
//    stalled, set by combinational step logic updating mode and counters in place.
//  - Stall: when the result register holds a beat that is stalled, the input
//    register keeps its beat and o_in_stall rises only if it is also full, so
//    up to two beats are held inside.
//  - Reset (synchronous, active low): mode back to wait-for-motion, all counts
//    and config registers to zero, both pipeline stages empty.
`include "motion_reward_sequencer_macros.svh"

module motion_reward_sequencer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input beats
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [mrs_pkg::VEL_WIDTH-1:0] i_velocity,
    // result beats
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_reward_pulse,
    output logic [1:0]                           o_mode_now,
    output logic [5:0]                           o_status_word,
    // config writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mrs_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [mrs_pkg::CFG_WIDTH-1:0]        i_cfg_data
);

    mrs_pkg::t_cfg   s_cfg;
    mrs_pkg::t_state r_state;
    mrs_pkg::t_state n_state;
    logic            n_pulse;

    // input register
    logic                                 r_in_valid;
    logic signed [mrs_pkg::VEL_WIDTH-1:0] r_in_vel;

    // result register
    logic       r_out_valid;
    logic       r_pulse;
    logic [1:0] r_mode_code;

    logic          s_move;   // input-register beat steps into the result register
    logic          s_in_acc;
    mrs_pkg::t_mode s_mode_succ;

    assign o_cfg_ready = 1'b1;

    mrs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    mrs_step u_step (
        .i_velocity (r_in_vel),
        .i_cfg      (s_cfg),
        .i_state    (r_state),
        .o_state    (n_state),
        .o_pulse    (n_pulse)
    );

    assign s_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !s_move;
    assign s_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (s_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_in_vel <= i_velocity;
        end
    end

    // sequencer state advances once per beat taken into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode          <= mrs_pkg::MODE_WAIT_MOTION;
            r_state.running_count <= '0;
            r_state.still_count   <= '0;
            r_state.dwell_count   <= '0;
        end else if (s_move) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_move) begin
            r_pulse     <= n_pulse;
            r_mode_code <= mrs_pkg::mode_code(n_state.mode);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reward_pulse = r_pulse;
    assign o_mode_now     = r_mode_code;
    assign o_status_word  = {r_mode_code, 3'b000, r_pulse};

    // next mode in the rotation, for the transition check
    assign s_mode_succ = mrs_pkg::t_mode'({r_state.mode[2:0], r_state.mode[3]});

    // checks
    `MRS_ASSERT_NEXT(a_mode_holds_idle, !s_move, $stable(r_state))
    `MRS_ASSERT_NEXT(a_mode_steps_by_one, s_move,
        r_state.mode == $past(r_state.mode) || r_state.mode == $past(s_mode_succ))
    `MRS_ASSERT_NEXT(a_wait_reward_enters, s_move && n_pulse && (r_state.mode == mrs_pkg::MODE_WAIT_MOTION || r_state.mode == mrs_pkg::MODE_WAIT_STILL), r_state.mode == $past(s_mode_succ))
    `MRS_ASSERT_NOW(a_stall_only_full, o_in_stall, r_in_valid && r_out_valid)

endmodule

// ===== sim/mrs_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the motion reward sequencer: tracks config writes, predicts each tick.
// Compares result beats in order; depends on mrs_pkg for widths and codes.
module mrs_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic signed [mrs_pkg::VEL_WIDTH-1:0] i_velocity,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic                                 i_reward_pulse,
    input  logic [1:0]                           i_mode_now,
    input  logic [5:0]                           i_status_word,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [mrs_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [mrs_pkg::CFG_WIDTH-1:0]        i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    localparam int CW         = mrs_pkg::COUNT_WIDTH;
    localparam int RW         = mrs_pkg::CFG_WIDTH;
    localparam int MODE_SHIFT = 4;

    typedef struct packed {
        logic       reward;
        logic [1:0] mode;
        logic [5:0] status;
    } t_tick_result;

    logic signed [RW-1:0] vel_threshold = '0;
    logic [RW-1:0]        run_need      = '0;
    logic [RW-1:0]        still_need    = '0;
    logic [RW-1:0]        motion_len    = '0;
    logic [RW-1:0]        still_len     = '0;

    logic [1:0]    mode_code = mrs_pkg::CODE_WAIT_MOTION;
    logic [CW-1:0] run_cnt   = '0;
    logic [CW-1:0] still_cnt = '0;
    logic [CW-1:0] dwell_cnt = '0;

    t_tick_result expected_ticks[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic bit met(input logic [CW-1:0] c, input logic [RW-1:0] need);
        return 64'(c) >= 64'(need);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    // one frame tick: counts first, then the mode decision
    task automatic step_tick(input logic signed [RW-1:0] vel, output t_tick_result res);
        logic pulse;
        pulse = 1'b0;
        if (vel > vel_threshold) begin
            still_cnt = '0;
            run_cnt   = bump(run_cnt);
        end else begin
            run_cnt   = '0;
            still_cnt = bump(still_cnt);
        end
        case (mode_code)
            mrs_pkg::CODE_WAIT_MOTION: begin
                if (met(run_cnt, run_need)) begin
                    pulse     = 1'b1;
                    run_cnt   = '0;
                    mode_code = mrs_pkg::CODE_REWARD_MOTION;
                end
            end
            mrs_pkg::CODE_REWARD_MOTION: begin
                dwell_cnt = bump(dwell_cnt);
                if (met(dwell_cnt, motion_len)) begin
                    dwell_cnt = '0;
                    mode_code = mrs_pkg::CODE_WAIT_STILL;
                end
                if (met(run_cnt, run_need)) begin
                    pulse   = 1'b1;
                    run_cnt = '0;
                end
            end
            mrs_pkg::CODE_WAIT_STILL: begin
                if (met(still_cnt, still_need)) begin
                    pulse     = 1'b1;
                    still_cnt = '0;
                    mode_code = mrs_pkg::CODE_REWARD_STILL;
                end
            end
            default: begin
                dwell_cnt = bump(dwell_cnt);
                if (met(dwell_cnt, still_len)) begin
                    dwell_cnt = '0;
                    mode_code = mrs_pkg::CODE_WAIT_MOTION;
                end
                if (met(still_cnt, still_need)) begin
                    pulse     = 1'b1;
                    still_cnt = '0;
                end
            end
        endcase
        res.reward = pulse;
        res.mode   = mode_code;
        res.status = 6'(pulse) + (6'(mode_code) << MODE_SHIFT);
    endtask

    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result fresh;
        if (!i_rst_n) begin
            vel_threshold = '0;
            run_need      = '0;
            still_need    = '0;
            motion_len    = '0;
            still_len     = '0;
            mode_code     = mrs_pkg::CODE_WAIT_MOTION;
            run_cnt       = '0;
            still_cnt     = '0;
            dwell_cnt     = '0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mrs_pkg::CFG_VEL_THRESHOLD:     vel_threshold = i_cfg_data;
                    mrs_pkg::CFG_RUN_TICKS_NEED:    run_need      = i_cfg_data;
                    mrs_pkg::CFG_STILL_TICKS_NEED:  still_need    = i_cfg_data;
                    mrs_pkg::CFG_MOTION_MODE_TICKS: motion_len    = i_cfg_data;
                    mrs_pkg::CFG_STILL_MODE_TICKS:  still_len     = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_ticks.size() == 0) begin
                    report_mismatch("result beat with nothing pending, status", i_status_word, -1);
                end else begin
                    want = expected_ticks.pop_front();
                    if (i_reward_pulse !== want.reward)
                        report_mismatch("reward_pulse", i_reward_pulse, want.reward);
                    if (i_mode_now !== want.mode)
                        report_mismatch("mode_now", i_mode_now, want.mode);
                    if (i_status_word !== want.status)
                        report_mismatch("status_word", i_status_word, want.status);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                step_tick(i_velocity, fresh);
                expected_ticks.push_back(fresh);
            end
        end
        o_pending <= expected_ticks.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the motion reward sequencer bench: clock, reset, stimulus and verdict.
// Depends on mrs_pkg, the motion_reward_sequencer RTL and mrs_checker.
module tb_top;

    localparam int CW            = mrs_pkg::CFG_WIDTH;
    localparam int SOAK_TICKS    = 40;      // back-to-back stationary ticks, unreachable threshold
    localparam int PHASES        = 10;
    localparam int PHASE_TICKS   = 125;
    localparam int LONG_HOLD     = 64;      // receiver back-pressure stretch, in cycles
    localparam int SETTLE_CYCLES = 4;       // two-stage pipeline plus margin
    localparam int CYCLE_LIMIT   = 500000;

    // indexes past the register map; writes there must be dropped
    localparam logic [mrs_pkg::CFG_IDX_WIDTH-1:0] CFG_UNMAPPED_LO = 3'd5;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic signed [CW-1:0] velocity   = '0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [mrs_pkg::CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [CW-1:0]        cfg_data   = '0;

    logic       in_stall;
    logic       out_valid;
    logic       reward_pulse;
    logic [1:0] mode_now;
    logic [5:0] status_word;
    logic       cfg_ready;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // idle knobs for the sender task and the receiver process, plus the long-hold request
    bit tx_idle       = 1'b1;
    bit rx_idle       = 1'b1;
    bit long_hold_req = 1'b0;

    // motion/stillness run generator state
    int current_thr = 0;
    int run_left    = 0;
    bit run_moving  = 1'b0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    motion_reward_sequencer i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_velocity     (velocity),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_reward_pulse (reward_pulse),
        .o_mode_now     (mode_now),
        .o_status_word  (status_word),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    mrs_checker i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_velocity     (velocity),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_reward_pulse (reward_pulse),
        .i_mode_now     (mode_now),
        .i_status_word  (status_word),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Send one tick beat. Valid stays high across back-to-back beats so it
    // never gets a low and a high in the same step; returns right after the
    // edge that took the beat.
    task automatic send_tick(input logic signed [CW-1:0] v);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        velocity <= v;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid, then wait until the checker holds no more expectations.
    // The first edge lets the last accepted beat reach the pending count.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Config beat; cfg_valid is left high so back-to-back writes stay clean
    task automatic put_reg(input logic [mrs_pkg::CFG_IDX_WIDTH-1:0] idx, input logic [CW-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // All five registers, optionally followed by a write to an unmapped index
    task automatic program_regs(input int thr, input int run_need, input int still_need,
                                input int motion_len, input int still_len, input bit junk);
        put_reg(mrs_pkg::CFG_VEL_THRESHOLD,     CW'(thr));
        put_reg(mrs_pkg::CFG_RUN_TICKS_NEED,    CW'(run_need));
        put_reg(mrs_pkg::CFG_STILL_TICKS_NEED,  CW'(still_need));
        put_reg(mrs_pkg::CFG_MOTION_MODE_TICKS, CW'(motion_len));
        put_reg(mrs_pkg::CFG_STILL_MODE_TICKS,  CW'(still_len));
        if (junk)
            put_reg(CFG_UNMAPPED_LO + 3'($urandom_range(0, 2)), CW'($urandom));
        cfg_valid <= 1'b0;
        current_thr = thr;
    endtask

    // Mostly runs of running or stationary ticks so the counts climb to their
    // thresholds; some noise and some ticks sitting exactly on the threshold.
    function automatic logic signed [CW-1:0] next_velocity();
        int pick;
        pick = $urandom_range(0, 99);
        if (run_left == 0) begin
            run_left   = $urandom_range(1, 12);
            run_moving = $urandom_range(0, 1);
        end
        run_left--;
        if (pick < 15)
            return CW'($urandom);
        if (pick < 20)
            return CW'(current_thr);
        if (run_moving && current_thr < 32767)
            return CW'(current_thr + 1 + int'($urandom_range(0, 32766 - current_thr)));
        return CW'(current_thr - int'($urandom_range(0, current_thr + 32768)));
    endfunction

    // Receiver: random stall before each beat, or one long hold when asked.
    initial begin : receiver
        int w;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (long_hold_req) begin
                w = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                w = rx_idle ? $urandom_range(0, 8) : 0;
            end
            if (w > 0) begin
                out_stall <= 1'b1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        logic signed [CW-1:0] edge_vels [12];
        logic signed [CW-1:0] top_vels  [8];
        int thr;
        int run_need;
        int still_need;
        int motion_len;
        int still_len;

        edge_vels = '{16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd0,
                      16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd1, 16'sd0};
        top_vels  = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                      -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32766};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset config: every threshold and mode length zero, so the mode walks
        // one step per tick; twelve ticks leave it back in wait-for-motion.
        // Velocity equal to the zero threshold counts as stationary.
        foreach (edge_vels[j]) send_tick(edge_vels[j]);
        settle();

        // Unreachable thresholds: park in wait-for-motion while still_count
        // climbs with back-to-back ticks.
        program_regs(0, 16'hFFFF, 16'hFFFF, 0, 0, 1'b0);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (SOAK_TICKS) send_tick(CW'(-int'($urandom_range(0, 32768))));
        settle();
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // Walk to wait-for-stillness; still_count stays far below the
        // maximum threshold, so the block waits there.
        program_regs(0, 0, 16'hFFFF, 0, 0, 1'b1);
        send_tick(-16'sd32768);
        send_tick(16'sd0);
        send_tick(-16'sd5);
        settle();

        // Top threshold: nothing can be running, not even the top velocity.
        program_regs(32767, 2, 2, 3, 3, 1'b1);
        foreach (top_vels[j]) send_tick(top_vels[j]);
        settle();

        for (int k = 0; k < PHASES; k++) begin
            if (k == 0)
                thr = -32768;
            else if (k == 1)
                thr = 32767;
            else if (k % 3 == 2)
                thr = int'($signed(CW'($urandom)));
            else
                thr = int'($urandom_range(0, 1200)) - 600;

            if (k == 2) begin
                run_need   = 16'hFFFF;
                still_need = $urandom_range(0, 6);
                motion_len = 16'hFFFF;
                still_len  = 16'hFFFF;
            end else if (k == 4) begin
                run_need   = 0;
                still_need = 0;
                motion_len = 0;
                still_len  = 0;
            end else begin
                run_need   = $urandom_range(0, 6);
                still_need = $urandom_range(0, 6);
                motion_len = $urandom_range(0, 10);
                still_len  = $urandom_range(0, 10);
            end
            program_regs(thr, run_need, still_need, motion_len, still_len, k[0]);

            // every fourth phase runs without gaps on either side
            tx_idle = (k % 4 != 3);
            rx_idle = (k % 4 != 3);
            if (k == 5) begin
                // sender keeps pushing while the receiver holds off, so the
                // two internal stages fill and the input stalls
                tx_idle       = 1'b0;
                long_hold_req = 1'b1;
            end
            repeat (PHASE_TICKS) send_tick(next_velocity());
            settle();
        end

        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
